// File: hw/rtl/assert_macros.svh
// Assertion macros for the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FCTP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in %m");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FCTP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in %m");

`endif

// File: hw/rtl/fctp_pkg.sv
// Types, constants and register codes of the frame code test pattern unit.
package fctp_pkg;

    localparam int FRAME_W   = 32;
    localparam int COORD_W   = 12;
    localparam int DIM_W     = 13;
    localparam int LEVEL_W   = 8;
    localparam int DIM_MAX   = 4096;

    localparam int BAR_COUNT  = 20;
    localparam int FIXED_BARS = 4;
    localparam int GRAY_BITS  = BAR_COUNT - FIXED_BARS;
    localparam int STEP_W     = $clog2(BAR_COUNT);
    localparam int ACC_W      = $clog2(BAR_COUNT * DIM_MAX + 1);
    localparam int POS_W      = 7;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd960;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd540;

    // Reciprocals for division by constants: n/5, n/3 and n/119.
    localparam logic [15:0] RECIP_5   = 16'd52429;   // >> 18
    localparam logic [9:0]  RECIP_3   = 10'd683;     // >> 11
    localparam logic [19:0] RECIP_119 = 20'd563941;  // >> 26

    // 8-bit color levels.
    localparam logic [LEVEL_W-1:0] BG_ODD   = 8'd41;
    localparam logic [LEVEL_W-1:0] BG_EVEN  = 8'd31;
    localparam logic [LEVEL_W-1:0] BG_BLUE  = 8'd56;
    localparam logic [LEVEL_W-1:0] SWEEP_RG = 8'd242;
    localparam logic [LEVEL_W-1:0] SWEEP_B  = 8'd38;
    localparam logic [LEVEL_W-1:0] FULL     = 8'd255;
    localparam logic [LEVEL_W-1:0] DARK     = 8'd0;

    typedef enum logic {
        CFG_IDLE,
        CFG_CALC
    } cfg_state_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_number;
        logic [COORD_W-1:0] pixel_column;
        logic [COORD_W-1:0] pixel_row;
    } pixel_in_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
    } pixel_out_t;

    // Frame geometry derived from the two size registers.
    typedef struct packed {
        logic [DIM_W-1:0] frame_w;
        logic [DIM_W-1:0] frame_h;
        logic [9:0]       band_h;
        logic [DIM_W-1:0] band_top;
        logic [10:0]      patch_top;
        logic [8:0]       sweep_w;
        logic [DIM_W-1:0] sweep_span;
        logic [8:0]       patch_w;
        logic [DIM_W-1:0] patch_left;
    } geom_t;

    // Per-pixel shape flags carried down the pipeline.
    typedef struct packed {
        logic odd;
        logic band_hit;
        logic bar_white;
        logic mid_row;
        logic patch_row;
        logic patch_black;
        logic patch_white;
    } paint_t;

endpackage

// File: hw/rtl/fctp_cfg.sv
// Size registers, derived geometry and bar boundary table with its settle pass.
module fctp_cfg (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           cfg_valid,
    output logic                                           cfg_ready,
    input  logic [fctp_pkg::CFG_INDEX_W-1:0]               cfg_index,
    input  logic [fctp_pkg::DIM_W-1:0]                     cfg_data,
    output logic                                           settling,
    output fctp_pkg::geom_t                                geom,
    output logic [fctp_pkg::BAR_COUNT-1:0][fctp_pkg::DIM_W-1:0] bar_hi
);

    fctp_pkg::cfg_state_t               state_reg, state_next;
    logic [fctp_pkg::STEP_W-1:0]        step_reg, step_next;
    logic [fctp_pkg::ACC_W-1:0]         acc_reg, acc_next;
    logic [fctp_pkg::DIM_W-1:0]         w_reg, h_reg;
    fctp_pkg::geom_t                    geom_reg, geom_next;
    logic [fctp_pkg::BAR_COUNT-1:0][fctp_pkg::DIM_W-1:0] hi_reg;

    logic                               wr;
    logic [fctp_pkg::ACC_W-1:0]         acc_sum;
    logic [30:0]                        div_prod;
    logic [20:0]                        ph_prod;
    logic [19:0]                        sw_prod;
    logic [9:0]                         bh;
    logic [9:0]                         ph;
    logic [8:0]                         sw_raw;
    logic [8:0]                         sw;
    logic [8:0]                         pw;

    function automatic logic [fctp_pkg::DIM_W-1:0] clamp_dim(
        input logic [fctp_pkg::DIM_W-1:0] v
    );
        if (v == '0)
            return fctp_pkg::DIM_W'(1);
        else if (v > fctp_pkg::DIM_W'(fctp_pkg::DIM_MAX))
            return fctp_pkg::DIM_W'(fctp_pkg::DIM_MAX);
        else
            return v;
    endfunction

    assign cfg_ready = (state_reg == fctp_pkg::CFG_IDLE);
    assign settling  = (state_reg == fctp_pkg::CFG_CALC);
    assign wr        = cfg_valid && cfg_ready;

    // Boundary b: (b+1)*W/20, taken as ((n>>2)*RECIP_5)>>18.
    assign acc_sum  = acc_reg + fctp_pkg::ACC_W'(w_reg);
    assign div_prod = 31'(acc_sum[fctp_pkg::ACC_W-1:2]) * 31'(fctp_pkg::RECIP_5);

    // H/12 = (H>>2)/3 and W/24 = (W>>3)/3.
    assign ph_prod = 21'(h_reg[fctp_pkg::DIM_W-1:2]) * 21'(fctp_pkg::RECIP_3);
    assign sw_prod = 20'(w_reg[fctp_pkg::DIM_W-1:3]) * 20'(fctp_pkg::RECIP_3);
    assign bh      = h_reg[fctp_pkg::DIM_W-1:3];
    assign ph      = ph_prod[20:11];
    assign sw_raw  = sw_prod[19:11];
    assign sw      = (sw_raw == '0) ? 9'd1 : sw_raw;
    assign pw      = w_reg[fctp_pkg::DIM_W-1:4];

    always_comb
    begin
        geom_next.frame_w    = w_reg;
        geom_next.frame_h    = h_reg;
        geom_next.band_h     = bh;
        geom_next.band_top   = h_reg - fctp_pkg::DIM_W'(bh);
        geom_next.patch_top  = 11'(bh) + 11'(ph);
        geom_next.sweep_w    = sw;
        geom_next.sweep_span = w_reg - fctp_pkg::DIM_W'(sw);
        geom_next.patch_w    = pw;
        geom_next.patch_left = w_reg - fctp_pkg::DIM_W'(pw);
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        acc_next   = acc_reg;
        unique case (state_reg)
            fctp_pkg::CFG_IDLE:
            begin
                if (wr)
                begin
                    state_next = fctp_pkg::CFG_CALC;
                    step_next  = '0;
                    acc_next   = '0;
                end
            end
            fctp_pkg::CFG_CALC:
            begin
                acc_next  = acc_sum;
                step_next = step_reg + 1'b1;
                if (step_reg == fctp_pkg::STEP_W'(fctp_pkg::BAR_COUNT - 1))
                    state_next = fctp_pkg::CFG_IDLE;
            end
            default:
            begin
                state_next = fctp_pkg::CFG_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fctp_pkg::CFG_CALC;
            step_reg  <= '0;
            acc_reg   <= '0;
            w_reg     <= fctp_pkg::WIDTH_RESET;
            h_reg     <= fctp_pkg::HEIGHT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            acc_reg   <= acc_next;
            if (wr && cfg_index == fctp_pkg::CFG_FRAME_WIDTH)
                w_reg <= clamp_dim(cfg_data);
            if (wr && cfg_index == fctp_pkg::CFG_FRAME_HEIGHT)
                h_reg <= clamp_dim(cfg_data);
        end
    end

    // Fill one boundary per cycle of the settle pass.
    always_ff @(posedge clk)
    begin
        if (settling)
        begin
            hi_reg[step_reg] <= div_prod[30:18];
            geom_reg         <= geom_next;
        end
    end

    assign geom   = geom_reg;
    assign bar_hi = hi_reg;

endmodule

// File: hw/rtl/fctp_front.sv
// Stages 1 and 2: row and column tests, bar decode, frame phase mod 120.
module fctp_front (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           in_valid,
    input  fctp_pkg::pixel_in_t                            item,
    input  fctp_pkg::geom_t                                geom,
    input  logic [fctp_pkg::BAR_COUNT-1:0][fctp_pkg::DIM_W-1:0] bar_hi,
    output logic                                           out_valid,
    output logic [fctp_pkg::POS_W-1:0]                     sweep_pos,
    output logic [fctp_pkg::COORD_W-1:0]                   col,
    output fctp_pkg::paint_t                               paint
);

    logic [fctp_pkg::DIM_W-1:0]     x13, y13;
    logic [31:0]                    f_hi;
    logic [6:0]                     nib_sum;
    logic [fctp_pkg::GRAY_BITS:0]   f_low;
    logic [fctp_pkg::BAR_COUNT-1:0] thermo;

    logic                           s1_valid_reg;
    logic [6:0]                     s1_nib_reg;
    logic [2:0]                     s1_low_reg;
    logic [fctp_pkg::GRAY_BITS-1:0] s1_gray_reg;
    logic [fctp_pkg::COORD_W-1:0]   s1_x_reg;
    logic                           s1_band_reg, s1_mid_reg, s1_prow_reg;
    logic                           s1_pblack_reg, s1_pwhite_reg;
    logic [fctp_pkg::BAR_COUNT-1:0] s1_thermo_reg;

    logic [4:0]                     fold;
    logic [3:0]                     m15;
    logic [fctp_pkg::BAR_COUNT-1:0] bar_sel;
    logic [fctp_pkg::BAR_COUNT-1:0] bar_bits;
    fctp_pkg::paint_t               paint_next;

    logic                           s2_valid_reg;
    logic [fctp_pkg::POS_W-1:0]     s2_pos_reg;
    logic [fctp_pkg::COORD_W-1:0]   s2_x_reg;
    fctp_pkg::paint_t               s2_paint_reg;

    assign x13   = fctp_pkg::DIM_W'(item.pixel_column);
    assign y13   = fctp_pkg::DIM_W'(item.pixel_row);
    assign f_hi  = 32'(item.frame_number[fctp_pkg::FRAME_W-1:3]);
    assign f_low = item.frame_number[fctp_pkg::GRAY_BITS:0];

    // f mod 120 = 8*((f>>3) mod 15) + f[2:0]; mod 15 by nibble sums.
    always_comb
    begin
        nib_sum = '0;
        for (int i = 0; i < 8; i++)
            nib_sum = nib_sum + 7'(f_hi[4*i +: 4]);
    end

    always_comb
    begin
        for (int b = 0; b < fctp_pkg::BAR_COUNT; b++)
            thermo[b] = (x13 >= bar_hi[b]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        s1_nib_reg    <= nib_sum;
        s1_low_reg    <= item.frame_number[2:0];
        s1_gray_reg   <= f_low[fctp_pkg::GRAY_BITS-1:0] ^ f_low[fctp_pkg::GRAY_BITS:1];
        s1_x_reg      <= item.pixel_column;
        s1_band_reg   <= (y13 < fctp_pkg::DIM_W'(geom.band_h))
                         || (y13 >= geom.band_top && y13 < geom.frame_h);
        s1_mid_reg    <= (y13 >= fctp_pkg::DIM_W'(geom.band_h)) && (y13 < geom.band_top);
        s1_prow_reg   <= (y13 >= fctp_pkg::DIM_W'(geom.band_h))
                         && (y13 < fctp_pkg::DIM_W'(geom.patch_top));
        s1_pblack_reg <= (x13 < fctp_pkg::DIM_W'(geom.patch_w));
        s1_pwhite_reg <= (x13 >= geom.patch_left) && (x13 < geom.frame_w);
        s1_thermo_reg <= thermo;
    end

    // Finish mod 15, pick the bar the column falls in.
    assign fold = 5'(s1_nib_reg[6:4]) + 5'(s1_nib_reg[3:0]);
    assign m15  = (fold >= 5'd15) ? 4'(fold - 5'd15) : fold[3:0];

    always_comb
    begin
        for (int b = 0; b < fctp_pkg::BAR_COUNT; b++)
        begin
            if (b == 0)
                bar_sel[b] = !s1_thermo_reg[b];
            else
                bar_sel[b] = s1_thermo_reg[b-1] && !s1_thermo_reg[b];
            if (b < fctp_pkg::FIXED_BARS)
                bar_bits[b] = ((b % 2) == 0);
            else
                bar_bits[b] = s1_gray_reg[b - fctp_pkg::FIXED_BARS];
        end
    end

    always_comb
    begin
        paint_next.odd         = s1_low_reg[0];
        paint_next.band_hit    = s1_band_reg && !s1_thermo_reg[fctp_pkg::BAR_COUNT-1];
        paint_next.bar_white   = |(bar_sel & bar_bits);
        paint_next.mid_row     = s1_mid_reg;
        paint_next.patch_row   = s1_prow_reg;
        paint_next.patch_black = s1_pblack_reg;
        paint_next.patch_white = s1_pwhite_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_pos_reg   <= {m15, s1_low_reg};
        s2_x_reg     <= s1_x_reg;
        s2_paint_reg <= paint_next;
    end

    assign out_valid = s2_valid_reg;
    assign sweep_pos = s2_pos_reg;
    assign col       = s2_x_reg;
    assign paint     = s2_paint_reg;

endmodule

// File: hw/rtl/fctp_sweep.sv
// Stages 3 and 4: sweep bar start column, phase * (W - sw) / 119.
module fctp_sweep (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [fctp_pkg::POS_W-1:0]         sweep_pos,
    input  logic [fctp_pkg::COORD_W-1:0]       in_col,
    input  fctp_pkg::paint_t                   in_paint,
    input  fctp_pkg::geom_t                    geom,
    output logic                               out_valid,
    output logic [fctp_pkg::COORD_W-1:0]       out_col,
    output fctp_pkg::paint_t                   out_paint,
    output logic [fctp_pkg::DIM_W-1:0]         sweep_x
);

    logic                           s3_valid_reg;
    logic [19:0]                    s3_prod_reg;
    logic [fctp_pkg::COORD_W-1:0]   s3_col_reg;
    fctp_pkg::paint_t               s3_paint_reg;

    logic [39:0]                    q_prod;

    logic                           s4_valid_reg;
    logic [fctp_pkg::DIM_W-1:0]     s4_sx_reg;
    logic [fctp_pkg::COORD_W-1:0]   s4_col_reg;
    fctp_pkg::paint_t               s4_paint_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s3_valid_reg <= in_valid;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Divide by 119 through the reciprocal, exact for the 19-bit product range.
    assign q_prod = 40'(s3_prod_reg) * 40'(fctp_pkg::RECIP_119);

    always_ff @(posedge clk)
    begin
        s3_prod_reg  <= 20'(sweep_pos) * 20'(geom.sweep_span);
        s3_col_reg   <= in_col;
        s3_paint_reg <= in_paint;
        s4_sx_reg    <= q_prod[38:26];
        s4_col_reg   <= s3_col_reg;
        s4_paint_reg <= s3_paint_reg;
    end

    assign out_valid = s4_valid_reg;
    assign out_col   = s4_col_reg;
    assign out_paint = s4_paint_reg;
    assign sweep_x   = s4_sx_reg;

endmodule

// File: hw/rtl/frame_code_test_pattern_unit.sv
// Top level of the frame code test pattern unit: per-pixel timing test pattern.
//
// Usage:
//   Pixel channel: drive item (frame number, column, row counted from the
//   bottom edge) with start high; the beat is taken at an edge where busy is
//   low. One pixel may be taken every cycle.
//   Result channel: done is high for exactly one cycle with the RGB beat on
//   result, once the pixel has passed the front, sweep and output registers.
//   The receiver cannot stall: results are never held and never dropped.
//   Config channel: cfg_valid/cfg_ready with cfg_index (0 frame width,
//   1 frame height) and cfg_data. Sizes of 0 act as 1, above 4096 as 4096;
//   unknown indexes change no size. Write only while no pixel is in flight.
//   After each write the bar boundary table is rebuilt, one bar per cycle
//   from a shared adder and reciprocal multiplier: busy and !cfg_ready hold
//   until the last bar is done. The same pass runs right after reset, with the
//   sizes at 960 x 540.
//   Throughput: one pixel per cycle while busy is low; the path runs through the
//   front compare stages, the two sweep multiplier stages and the paint stage.
module frame_code_test_pattern_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  fctp_pkg::pixel_in_t                  item,
    output logic                                 done,
    output fctp_pkg::pixel_out_t                 result,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [fctp_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [fctp_pkg::DIM_W-1:0]           cfg_data
);

    logic                                                settling;
    fctp_pkg::geom_t                                     geom;
    logic [fctp_pkg::BAR_COUNT-1:0][fctp_pkg::DIM_W-1:0] bar_hi;

    logic                               accept;
    logic                               f_valid;
    logic [fctp_pkg::POS_W-1:0]         f_pos;
    logic [fctp_pkg::COORD_W-1:0]       f_col;
    fctp_pkg::paint_t                   f_paint;

    logic                               s_valid;
    logic [fctp_pkg::COORD_W-1:0]       s_col;
    fctp_pkg::paint_t                   s_paint;
    logic [fctp_pkg::DIM_W-1:0]         s_sx;

    logic [fctp_pkg::DIM_W-1:0]         x13;
    logic                               sweep_hit;
    fctp_pkg::pixel_out_t               color;

    logic                               done_reg;
    fctp_pkg::pixel_out_t               result_reg;

    // Pixels are refused only while the geometry is being rebuilt.
    assign busy   = settling;
    assign accept = start && !busy;

    fctp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .settling  (settling),
        .geom      (geom),
        .bar_hi    (bar_hi)
    );

    fctp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .item      (item),
        .geom      (geom),
        .bar_hi    (bar_hi),
        .out_valid (f_valid),
        .sweep_pos (f_pos),
        .col       (f_col),
        .paint     (f_paint)
    );

    fctp_sweep u_sweep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .sweep_pos (f_pos),
        .in_col    (f_col),
        .in_paint  (f_paint),
        .geom      (geom),
        .out_valid (s_valid),
        .out_col   (s_col),
        .out_paint (s_paint),
        .sweep_x   (s_sx)
    );

    // Paint in order: background, code bands, sweep bar, black then white patch.
    assign x13       = fctp_pkg::DIM_W'(s_col);
    assign sweep_hit = s_paint.mid_row && (x13 >= s_sx)
                       && ((x13 - s_sx) < fctp_pkg::DIM_W'(geom.sweep_w));

    always_comb
    begin
        if (s_paint.odd)
        begin
            color.red_level   = fctp_pkg::BG_ODD;
            color.green_level = fctp_pkg::BG_ODD;
        end
        else
        begin
            color.red_level   = fctp_pkg::BG_EVEN;
            color.green_level = fctp_pkg::BG_EVEN;
        end
        color.blue_level = fctp_pkg::BG_BLUE;

        if (s_paint.band_hit)
        begin
            color.red_level   = s_paint.bar_white ? fctp_pkg::FULL : fctp_pkg::DARK;
            color.green_level = s_paint.bar_white ? fctp_pkg::FULL : fctp_pkg::DARK;
            color.blue_level  = s_paint.bar_white ? fctp_pkg::FULL : fctp_pkg::DARK;
        end

        if (sweep_hit)
        begin
            color.red_level   = fctp_pkg::SWEEP_RG;
            color.green_level = fctp_pkg::SWEEP_RG;
            color.blue_level  = fctp_pkg::SWEEP_B;
        end

        if (s_paint.patch_row && s_paint.patch_black)
        begin
            color.red_level   = fctp_pkg::DARK;
            color.green_level = fctp_pkg::DARK;
            color.blue_level  = fctp_pkg::DARK;
        end

        if (s_paint.patch_row && s_paint.patch_white)
        begin
            color.red_level   = fctp_pkg::FULL;
            color.green_level = fctp_pkg::FULL;
            color.blue_level  = fctp_pkg::FULL;
        end
    end

    // Output register: the strobe lasts one cycle per beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= s_valid;
    end

    always_ff @(posedge clk)
    begin
        result_reg <= color;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: hw/rtl/fctp_checker.sv
// Port-level checker for the frame code test pattern unit, bound to the top level.
`include "assert_macros.svh"

module fctp_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             done,
    input logic                             cfg_valid,
    input logic                             cfg_ready
);

    // A register write starts the boundary rebuild at once.
    `FCTP_ASSERT_NEXT(a_write_settles, cfg_valid && cfg_ready, busy)

    // Pixels are still refused at the sampled point near the end of the rebuild.
    `FCTP_ASSERT_IMPL(a_settle_length, $past(cfg_valid && cfg_ready, 19), busy)

    // Exactly one result beat per accepted pixel.
    `FCTP_ASSERT_IMPL(a_latency, 1'b1, done == $past(start && !busy, 5))

endmodule

bind frame_code_test_pattern_unit fctp_checker u_fctp_checker (.*);
